/* hw/rtl/dwsu_pkg.sv */
// ----------------------------------------------------------------------------
// dwsu_pkg
// types and constants shared by the wavetable sound unit
// ----------------------------------------------------------------------------
package dwsu_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  localparam logic [15:0] WAVE_BASE = 16'h4040;
  localparam logic [15:0] WAVE_LAST = 16'h407F;
  localparam logic [15:0] REG_BASE  = 16'h4080;
  localparam logic [15:0] REG_LAST  = 16'h408A;
  localparam logic [15:0] RD_GAIN0  = 16'h4090;
  localparam logic [15:0] RD_OPEN   = 16'h4091;
  localparam logic [15:0] RD_GAIN1  = 16'h4092;

  typedef struct packed {
    op_e         op;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  open_bus;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [11:0] sample;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic start;   // first step: register the item, table reads
    logic finish;  // second step: state update, result
  } dp_cmd_t;

endpackage

/* hw/rtl/dwsu_stream_if.sv */
// ----------------------------------------------------------------------------
// dwsu_stream_if
// valid/ready channel carrying one word
// ----------------------------------------------------------------------------
interface dwsu_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/dwsu_ctrl.sv */
// ----------------------------------------------------------------------------
// dwsu_ctrl
// two-step sequencer with output register handshake
// ----------------------------------------------------------------------------
module dwsu_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output dwsu_pkg::dp_cmd_t cmd_o
);
  import dwsu_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   ov_q, ov_d;

  // accept when idle and result slot free or being drained
  assign in_ready_o  = (state_q == ST_IDLE) && (!ov_q || out_ready_i);
  assign out_valid_o = ov_q;
  assign cmd_o.start  = in_valid_i && in_ready_o;
  assign cmd_o.finish = (state_q == ST_EXEC);

  always_comb begin
    state_d = state_q;
    ov_d    = ov_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: if (cmd_o.start) state_d = ST_EXEC;
      ST_EXEC: begin
        state_d = ST_IDLE;
        ov_d    = 1'b1;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end
endmodule

/* hw/rtl/dwsu_datapath.sv */
// ----------------------------------------------------------------------------
// dwsu_datapath
// registers, tables, phase accumulator, envelopes and sample scaling
// ----------------------------------------------------------------------------
module dwsu_datapath #(
  parameter int WAVE_ENTRIES = 64,
  parameter int MOD_ENTRIES  = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dwsu_pkg::dp_cmd_t    cmd_i,
  input  dwsu_pkg::in_word_t   in_i,
  output dwsu_pkg::out_word_t  out_o
);
  import dwsu_pkg::*;

  localparam int WA = $clog2(WAVE_ENTRIES);
  localparam int MA = $clog2(MOD_ENTRIES);

  logic [7:0]  regs_q [11];
  logic [5:0]  gain_q [2];
  logic [5:0]  step_q [2];
  logic [11:0] presc_q;
  logic [2:0]  phase_q;
  logic [18:0] fshift_q;
  logic [17:0] macc_q;
  logic [7:0]  gshift_q;
  logic [24:0] latch_q;
  logic [24:0] sum_q;
  logic [2:0]  mod_mem [MOD_ENTRIES];
  logic [5:0]  wave_mem [WAVE_ENTRIES];
  logic [MOD_ENTRIES-1:0]  mod_vld_q;
  logic [WAVE_ENTRIES-1:0] wave_vld_q;

  in_word_t    cur_q;
  logic [2:0]  mod_rd_q;
  logic [5:0]  wave_rd_q;
  logic        mod_rv_q, wave_rv_q;
  logic [5:0]  wave_sd_q;
  logic        wave_sv_q;
  out_word_t   out_q;

  // first step: register the item and read the tables
  logic [17:0] macc_pre;
  assign macc_pre = macc_q + {6'd0, regs_q[7][3:0], regs_q[6]};

  logic [MA-1:0] mod_ra;
  logic [WA-1:0] wave_ra;
  always_comb begin
    mod_ra  = macc_pre[13 +: MA];
    wave_ra = (in_i.op == OP_TICK) ? latch_q[19 +: WA] : in_i.address[WA-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cur_q     <= in_i;
      mod_rd_q  <= mod_mem[mod_ra];
      mod_rv_q  <= mod_vld_q[mod_ra];
      wave_rd_q <= wave_mem[wave_ra];
      wave_rv_q <= wave_vld_q[wave_ra];
    end
  end

  // second step decode
  logic is_wave, is_reg, wr_en, tk_en, wave_wr_on;
  logic [3:0] ridx;
  logic [15:0] roff;
  assign wave_wr_on = regs_q[9][7];
  assign is_wave = cur_q.address >= WAVE_BASE && cur_q.address <= WAVE_LAST;
  assign is_reg  = cur_q.address >= REG_BASE && cur_q.address <= REG_LAST;
  assign roff    = cur_q.address - REG_BASE;
  assign ridx    = roff[3:0];
  assign wr_en   = cmd_i.finish && cur_q.op == OP_WRITE;
  assign tk_en   = cmd_i.finish && cur_q.op == OP_TICK && !wave_wr_on;

  // modulation gain, clamped to signed byte
  logic [2:0]  tval;
  logic [5:0]  g1;
  logic [8:0]  mag;
  logic signed [10:0] adj;
  logic [7:0]  gs_load;
  always_comb begin
    tval = mod_rv_q ? mod_rd_q : 3'd0;
    g1   = gain_q[1];
    mag  = '0;
    adj  = '0;
    if (tval[1:0] != 2'd0) begin
      if (tval[2]) begin
        mag = 9'(g1) * (9'd4 - 9'(tval[1:0]));
        adj = -$signed({2'b00, mag});
      end else begin
        mag = 9'(g1) * 9'(tval[1:0]);
        adj = $signed({2'b00, mag});
      end
    end
    adj = adj <<< 1;
    if (adj > 11'sd127) adj = 11'sd127;
    if (adj < -11'sd128) adj = -11'sd128;
    gs_load = regs_q[7][7] ? 8'h80 : 8'(11'sd128 + adj);
  end

  // serial phase accumulator step
  logic [18:0] fs_n;
  logic [7:0]  gs_n;
  logic [24:0] sum_n, latch_n;
  always_comb begin
    if (phase_q == 3'd0) begin
      fs_n = {7'd0, regs_q[3][3:0], regs_q[2]};
      gs_n = gs_load;
    end else begin
      fs_n = {fshift_q[17:0], 1'b0};
      gs_n = {1'b0, gshift_q[7:1]};
    end
    sum_n   = latch_q + {6'd0, fs_n};
    latch_n = gs_n[0] ? sum_n : latch_q;
  end

  // second wave read at the advanced phase, picked once the gain bit is known
  logic [WA-1:0] wave_sa;
  assign wave_sa = sum_n[19 +: WA];
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      wave_sd_q <= wave_mem[wave_sa];
      wave_sv_q <= wave_vld_q[wave_sa];
    end
  end

  // envelope prescaler
  logic        fire;
  logic [13:0] pn;
  logic [11:0] presc_n;
  always_comb begin
    fire = presc_q <= 12'd1;
    pn   = {2'd0, presc_q} + 14'(3 * regs_q[10]);
    if (fire) presc_n = (pn >= 14'd1) ? 12'(pn - 14'd1) : 12'd0;
    else presc_n = presc_q - 12'd1;
  end

  // envelope step
  logic [5:0] gain_n [2];
  logic [5:0] step_n [2];
  always_comb begin
    for (int x = 0; x < 2; x++) begin
      gain_n[x] = gain_q[x];
      step_n[x] = step_q[x];
    end
    if (fire && !regs_q[3][6]) begin
      for (int x = 0; x < 2; x++) begin
        if (!regs_q[x*4][7]) begin
          if (step_q[x] == 6'd0) begin
            if (regs_q[x*4][6]) begin
              if (gain_q[x] < 6'h3F) gain_n[x] = gain_q[x] + 6'd1;
            end else if (gain_q[x] > 6'd0) gain_n[x] = gain_q[x] - 6'd1;
            step_n[x] = regs_q[x*4][5:0];
          end else step_n[x] = step_q[x] - 6'd1;
        end
      end
    end
  end

  // sample: wave * min(gain0,32) * 4 / (2..5)
  logic [5:0]  wv, k;
  logic [13:0] prod;
  logic [11:0] smp;
  always_comb begin
    if (gs_n[0]) wv = wave_sv_q ? wave_sd_q : 6'd0;
    else wv = wave_rv_q ? wave_rd_q : 6'd0;
    k    = (gain_n[0] > 6'h20) ? 6'h20 : gain_n[0];
    prod = {12'(wv) * 12'(k), 2'b00};
    case (regs_q[9][1:0])
      2'd0: smp = 12'(prod >> 1);
      2'd1: smp = 12'((30'(prod) * 30'd21846) >> 16);
      2'd2: smp = 12'(prod >> 2);
      default: smp = 12'((30'(prod) * 30'd13108) >> 16);
    endcase
  end

  // read mux
  logic [7:0] rd;
  always_comb begin
    rd = 8'd0;
    if (is_wave) rd = {cur_q.open_bus[7:6], (wave_rv_q ? wave_rd_q : 6'd0)};
    else if (cur_q.address == RD_GAIN0) rd = {cur_q.open_bus[7:6], gain_q[0]};
    else if (cur_q.address == RD_GAIN1) rd = {cur_q.open_bus[7:6], gain_q[1]};
    else if (cur_q.address == RD_OPEN) rd = cur_q.open_bus;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.read_data <= (cur_q.op == OP_READ) ? rd : 8'd0;
      out_q.sample    <= tk_en ? smp : 12'd0;
    end
  end
  assign out_o = out_q;

  // table writes
  logic [MA-1:0] mptr;
  assign mptr = regs_q[5][MA-1:0];
  always_ff @(posedge clk_i) begin
    if (wr_en && is_wave && wave_wr_on) wave_mem[cur_q.address[WA-1:0]] <= cur_q.write_data[5:0];
    if (wr_en && is_reg && ridx == 4'd8) mod_mem[mptr] <= cur_q.write_data[2:0];
  end

  // state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 11; i++) regs_q[i] <= '0;
      for (int i = 0; i < 2; i++) begin
        gain_q[i] <= '0;
        step_q[i] <= '0;
      end
      presc_q <= '0; phase_q <= '0; fshift_q <= '0; macc_q <= '0;
      gshift_q <= '0; latch_q <= '0; sum_q <= '0;
      mod_vld_q <= '0; wave_vld_q <= '0;
    end else if (wr_en) begin
      if (is_wave && wave_wr_on) wave_vld_q[cur_q.address[WA-1:0]] <= 1'b1;
      if (is_reg) begin
        if ((ridx == 4'd0 || ridx == 4'd4) && cur_q.write_data[7])
          gain_q[ridx[2]] <= cur_q.write_data[5:0];
        if (ridx == 4'd7 || ridx == 4'd8) macc_q <= '0;
        if (ridx == 4'd7) regs_q[5] <= '0;
        if (ridx == 4'd8) begin
          mod_vld_q[mptr] <= 1'b1;
          regs_q[5] <= 8'(MA'(mptr + 1'b1));
        end
        if (ridx != 4'd7 && ridx != 4'd8) regs_q[ridx] <= cur_q.write_data;
        else regs_q[ridx] <= cur_q.write_data;
      end
    end else if (tk_en) begin
      if (phase_q == 3'd0) macc_q <= macc_pre;
      fshift_q <= fs_n;
      gshift_q <= gs_n;
      sum_q    <= sum_n;
      latch_q  <= latch_n;
      phase_q  <= phase_q + 3'd1;
      presc_q  <= presc_n;
      for (int x = 0; x < 2; x++) begin
        gain_q[x] <= gain_n[x];
        step_q[x] <= step_n[x];
      end
    end
  end
endmodule

/* hw/rtl/disk_wavetable_sound_unit.sv */
// ----------------------------------------------------------------------------
// disk_wavetable_sound_unit
// wavetable sound unit: bus access and ticks through one word channel
// ----------------------------------------------------------------------------
// result: acceptance registers the word and table reads, the finish step loads the result
// a new word is taken only in idle, after the table read and update steps of the last one
// a waiting result holds off the next word until the cycle it is taken
// reset: asynchronous active low, clears control, registers, envelopes, accumulator and table valid bits
module disk_wavetable_sound_unit #(
  parameter int WAVE_ENTRIES = 64,
  parameter int MOD_ENTRIES  = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  dwsu_stream_if.sink   in_if,
  dwsu_stream_if.source out_if
);
  import dwsu_pkg::*;

  dp_cmd_t cmd;

  dwsu_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .cmd_o      (cmd)
  );

  dwsu_datapath #(.WAVE_ENTRIES(WAVE_ENTRIES), .MOD_ENTRIES(MOD_ENTRIES)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd),
    .in_i (in_if.data),
    .out_o(out_if.data)
  );

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |=> !cmd.start && cmd.finish) else $error("start overlap");
  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_if.valid) else $error("result lost");
  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.start && cmd.finish)) else $error("start during finish");
endmodule

/* bench/disk_wavetable_sound_unit_test.sv */
// ----------------------------------------------------------------------------
// disk_wavetable_sound_unit_test
// drives bus writes, reads and ticks into the sound unit and checks every
// result word against a cycle-free model of the registers, envelopes,
// modulated phase accumulator and wave output
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module disk_wavetable_sound_unit_test;
  import dwsu_pkg::*;

  logic clk_i;
  logic rst_ni;

  dwsu_stream_if #(.T(in_word_t))  cmd_ch ();
  dwsu_stream_if #(.T(out_word_t)) res_ch ();

  disk_wavetable_sound_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (cmd_ch.sink),
    .out_if (res_ch.source)
  );

  // model state
  logic [7:0]  m_regs [11];
  logic [5:0]  m_gain [2];
  logic [5:0]  m_env_cnt [2];
  logic [11:0] m_presc;
  logic [2:0]  m_phase;
  logic [18:0] m_freq_sh;
  logic [17:0] m_mod_acc;
  logic [7:0]  m_gain_sh;
  logic [24:0] m_latch;
  logic [2:0]  m_mod_tab [32];
  logic [5:0]  m_wave [64];

  in_word_t  pending_words [$];
  out_word_t expected_results [$];
  int        errors;
  int        n_sent;
  int        n_checked;
  bit        calm;
  bit        hold_sender;
  int        src_gap;
  int        snk_gap;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic model_reset();
    for (int i = 0; i < 11; i++) m_regs[i] = '0;
    for (int i = 0; i < 32; i++) m_mod_tab[i] = '0;
    for (int i = 0; i < 64; i++) m_wave[i] = '0;
    m_gain = '{default: '0};
    m_env_cnt = '{default: '0};
    m_presc = '0;
    m_phase = '0;
    m_freq_sh = '0;
    m_mod_acc = '0;
    m_gain_sh = '0;
    m_latch = '0;
  endtask

  function automatic void step_envelopes();
    logic [7:0] r;
    for (int x = 0; x < 2; x++) begin
      r = m_regs[x * 4];
      if (!(r[7] || m_regs[3][6])) begin
        if (m_env_cnt[x] == 0) begin
          if (r[6]) begin
            if (m_gain[x] < 6'h3F) m_gain[x] = m_gain[x] + 1;
          end else if (m_gain[x] > 0) begin
            m_gain[x] = m_gain[x] - 1;
          end
          m_env_cnt[x] = r[5:0];
        end else begin
          m_env_cnt[x] = m_env_cnt[x] - 1;
        end
      end
    end
  endfunction

  function automatic logic [11:0] tick_sample();
    logic [2:0]  t;
    int          adj;
    int          n;
    logic [24:0] sum;
    int          k;
    int          v;
    if (m_regs[9][7]) return '0;
    // one phase of the serial accumulator
    if (m_phase == 0) begin
      m_freq_sh = {7'd0, m_regs[3][3:0], m_regs[2]};
      m_mod_acc = m_mod_acc + {6'd0, m_regs[7][3:0], m_regs[6]};
      if (!m_regs[7][7]) begin
        t = m_mod_tab[m_mod_acc[17:13]];
        adj = 0;
        if (t[1:0] != 0) begin
          if (t[2]) adj = -(int'(m_gain[1]) * (4 - int'(t[1:0])));
          else adj = int'(m_gain[1]) * int'(t[1:0]);
        end
        adj = adj * 2;
        if (adj > 127) adj = 127;
        if (adj < -128) adj = -128;
        m_gain_sh = 8'(128 + adj);
      end else begin
        m_gain_sh = 8'h80;
      end
    end else begin
      m_freq_sh = m_freq_sh << 1;
      m_gain_sh = m_gain_sh >> 1;
    end
    sum = m_latch + 25'(m_freq_sh);
    if (m_gain_sh[0]) m_latch = sum;
    m_phase = m_phase + 1;
    // envelope prescaler
    if (m_presc <= 1) begin
      n = int'(m_presc) + 3 * int'(m_regs[10]);
      m_presc = (n >= 1) ? 12'(n - 1) : '0;
      step_envelopes();
    end else begin
      m_presc = m_presc - 1;
    end
    k = (m_gain[0] > 6'h20) ? 32 : int'(m_gain[0]);
    v = int'(m_wave[m_latch[24:19]]);
    return 12'((v * k * 4) / (int'(m_regs[9][1:0]) + 2));
  endfunction

  function automatic out_word_t predict_word(in_word_t w);
    out_word_t r;
    int        a;
    r = '0;
    a = int'(w.address);
    case (w.op)
      OP_WRITE: begin
        if (w.address >= WAVE_BASE && w.address <= WAVE_LAST) begin
          if (m_regs[9][7]) m_wave[a % 64] = w.write_data[5:0];
        end else if (w.address >= REG_BASE && w.address <= REG_LAST) begin
          a = a - int'(REG_BASE);
          if (a == 0 || a == 4) begin
            if (w.write_data[7]) m_gain[a / 4] = w.write_data[5:0];
          end else if (a == 7) begin
            m_mod_acc = '0;
            m_regs[5] = '0;
          end else if (a == 8) begin
            m_mod_acc = '0;
            m_mod_tab[m_regs[5][4:0]] = w.write_data[2:0];
            m_regs[5] = {3'd0, m_regs[5][4:0] + 5'd1};
          end
          m_regs[a] = w.write_data;
        end
      end
      OP_READ: begin
        if (w.address >= WAVE_BASE && w.address <= WAVE_LAST)
          r.read_data = {w.open_bus[7:6], m_wave[a % 64]};
        else if (w.address == RD_GAIN0) r.read_data = {w.open_bus[7:6], m_gain[0]};
        else if (w.address == RD_GAIN1) r.read_data = {w.open_bus[7:6], m_gain[1]};
        else if (w.address == RD_OPEN) r.read_data = w.open_bus;
      end
      OP_TICK: r.sample = tick_sample();
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_word_t make_word(op_e op, logic [15:0] a, logic [7:0] d);
    in_word_t w;
    w.op = op;
    w.address = a;
    w.write_data = d;
    w.open_bus = 8'($urandom);
    return w;
  endfunction

  task automatic push(op_e op, logic [15:0] a, logic [7:0] d);
    pending_words.push_back(make_word(op, a, d));
  endtask

  // a random word, mostly well-formed register traffic and ticks
  task automatic push_random();
    int          sel;
    logic [15:0] a;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      push(OP_TICK, 16'($urandom), 8'($urandom));
    end else if (sel < 65) begin
      a = REG_BASE + 16'($urandom_range(0, 10));
      push(OP_WRITE, a, 8'($urandom));
    end else if (sel < 73) begin
      push(OP_WRITE, WAVE_BASE + 16'($urandom_range(0, 63)), 8'($urandom));
    end else if (sel < 88) begin
      case ($urandom_range(0, 3))
        0: a = WAVE_BASE + 16'($urandom_range(0, 63));
        1: a = RD_GAIN0;
        2: a = RD_GAIN1;
        default: a = RD_OPEN;
      endcase
      push(OP_READ, a, 8'($urandom));
    end else if (sel < 95) begin
      push(op_e'($urandom_range(0, 1)), 16'($urandom), 8'($urandom));
    end else begin
      push(OP_NONE, 16'($urandom), 8'($urandom));
    end
  endtask

  // stimulus
  initial begin
    model_reset();
    errors = 0;
    calm = 1'b0;
    hold_sender = 1'b0;
    n_sent = 0;
    n_checked = 0;
    // directed: wave RAM writes and reads, gains, envelopes, modulation
    push(OP_WRITE, 16'h4089, 8'h80);
    push(OP_WRITE, WAVE_BASE, 8'hFF);
    push(OP_WRITE, WAVE_LAST, 8'h2A);
    push(OP_READ, WAVE_BASE, 8'h00);
    push(OP_READ, WAVE_LAST, 8'h00);
    push(OP_TICK, 16'h0, 8'h0);
    push(OP_WRITE, 16'h4089, 8'h03);
    push(OP_WRITE, WAVE_BASE, 8'h11);
    push(OP_WRITE, 16'h4080, 8'hBF);
    push(OP_WRITE, 16'h4084, 8'hA5);
    push(OP_READ, RD_GAIN0, 8'h00);
    push(OP_READ, RD_GAIN1, 8'h00);
    push(OP_READ, RD_OPEN, 8'h00);
    push(OP_READ, 16'hFFFF, 8'h00);
    push(OP_WRITE, 16'h0000, 8'hFF);
    push(OP_WRITE, 16'h4087, 8'h00);
    for (int i = 0; i < 4; i++) push(OP_WRITE, 16'h4088, 8'(i * 3 + 1));
    push(OP_WRITE, 16'h4082, 8'hFF);
    push(OP_WRITE, 16'h4083, 8'h0F);
    push(OP_WRITE, 16'h408A, 8'hFF);
    push(OP_NONE, 16'h4080, 8'hFF);
    for (int i = 0; i < 8; i++) push(OP_TICK, 16'h0, 8'h0);

    @(posedge rst_ni);
    for (int i = 0; i < 500; i++) push_random();
    // let everything drain once before carrying on
    wait (pending_words.size() == 0 && !cmd_ch.valid);
    hold_sender = 1'b1;
    wait (expected_results.size() == 0);
    @(posedge clk_i);
    hold_sender <= 1'b0;
    // envelopes running fast, modulation on, wave write off
    push(OP_WRITE, 16'h4089, 8'h00);
    push(OP_WRITE, 16'h408A, 8'h00);
    push(OP_WRITE, 16'h4080, 8'h41);
    push(OP_WRITE, 16'h4084, 8'h02);
    push(OP_WRITE, 16'h4083, 8'h0C);
    push(OP_WRITE, 16'h4087, 8'h01);
    for (int i = 0; i < 300; i++) push_random();
    wait (pending_words.size() < 50);
    calm = 1'b1;
    for (int i = 0; i < 200; i++) push_random();
  end

  // reset
  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver: one word from the queue per handshake, random idle bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_ch.valid <= 1'b0;
      cmd_ch.data <= '0;
      src_gap <= 0;
    end else if (!(cmd_ch.valid && !cmd_ch.ready)) begin
      if (cmd_ch.valid) begin
        expected_results.push_back(predict_word(cmd_ch.data));
        n_sent <= n_sent + 1;
      end
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        cmd_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 19) == 0) begin
        src_gap <= $urandom_range(1, 14);
        cmd_ch.valid <= 1'b0;
      end else if (!hold_sender && pending_words.size() > 0) begin
        cmd_ch.data <= pending_words.pop_front();
        cmd_ch.valid <= 1'b1;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: receiver stalls and word comparison
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t exp_w;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      snk_gap <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        n_checked <= n_checked + 1;
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          exp_w = expected_results.pop_front();
          if (res_ch.data.read_data !== exp_w.read_data) begin
            $error("read_data expected %0h got %0h", exp_w.read_data,
                   res_ch.data.read_data);
            errors++;
          end
          if (res_ch.data.sample !== exp_w.sample) begin
            $error("sample expected %0d got %0d", exp_w.sample, res_ch.data.sample);
            errors++;
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        res_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 19) == 0) begin
        snk_gap <= $urandom_range(1, 14);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // end of run
  initial begin
    wait (calm);
    wait (pending_words.size() == 0 && !cmd_ch.valid);
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      errors++;
    end
    $display("covered %0d words (writes, reads, ticks, idle ops), %0d results compared",
             n_sent, n_checked);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // timeout
  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/dwsu_pkg.sv
hw/rtl/dwsu_stream_if.sv
hw/rtl/dwsu_ctrl.sv
hw/rtl/dwsu_datapath.sv
hw/rtl/disk_wavetable_sound_unit.sv
bench/disk_wavetable_sound_unit_test.sv
